// ===== src/hsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types, widths, codes and the seed-to-home-slot table of the
// linear-probe slot allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

	// table size
	localparam int SLOTS = 10;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int FC_W  = $clog2(SLOTS + 1);

	// field widths
	localparam int TYPE_W = 2;
	localparam int SEED_W = 7;
	localparam int KEY_W  = 56;
	localparam int SIDX_W = 6;
	localparam int CODE_W = 3;
	localparam int CNT_W  = 7;

	// request types
	localparam logic [TYPE_W-1:0] REQ_PARK   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_VACATE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_LIST   = 2'd2;

	// result codes
	localparam logic [CODE_W-1:0] RC_PARKED  = 3'd0;
	localparam logic [CODE_W-1:0] RC_FULL    = 3'd1;
	localparam logic [CODE_W-1:0] RC_VACATED = 3'd2;
	localparam logic [CODE_W-1:0] RC_LISTED  = 3'd3;
	localparam logic [CODE_W-1:0] RC_SUMMARY = 3'd4;

	// one slot in the table RAM; a slot never written is tracked apart
	typedef struct packed {
		logic             occ;
		logic [KEY_W-1:0] key;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	// one result beat
	typedef struct packed {
		logic [SIDX_W-1:0] slot_index;
		logic [KEY_W-1:0]  slot_key;
		logic [CODE_W-1:0] result_code;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  used_count;
		logic              last;
	} rsp_t;

	// home slot for every possible seed, built at elaboration
	typedef logic [IDX_W-1:0] home_tbl_t [2**SEED_W];

	function automatic home_tbl_t build_home_tbl();
		home_tbl_t tbl;
		for (int s = 0; s < 2**SEED_W; s++) begin
			tbl[s] = IDX_W'(s % SLOTS);
		end
		return tbl;
	endfunction

	localparam home_tbl_t HOME_TBL = build_home_tbl();

endpackage
`default_nettype wire

// ===== src/hsa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module hsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/hsa_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_out
// Output register for result beats; frees itself in the cycle the
// receiver takes the held beat, so a new beat can load back to back.
// ----------------------------------------------------------------------------
module hsa_out (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire hsa_pkg::rsp_t push_data,
	output logic              ready,
	input  wire logic         stall,
	output logic              valid,
	output hsa_pkg::rsp_t     data
);

	logic          valid_q;
	hsa_pkg::rsp_t data_q;

	assign ready = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/hash_slot_allocator_linear_probe_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hash_slot_allocator_linear_probe_unit
// Slot table with open addressing, linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (req_valid / req_stall, fields req_type, hash_seed,
//  key_code): a beat is taken when req_valid is high and req_stall low.
//  req_stall is high from the accepted beat until its summary beat has
//  been loaded into the output register; one request is worked at a time.
//  Result channel (rsp_valid / rsp_stall): each request yields zero or more
//  per-slot beats and then one summary beat with last set. Counts on every
//  beat are those after the whole request.
//  Timing: the table RAM is read one slot per cycle while the output
//  register takes beats, a streamed read with registered read data. A park
//  probes from its home slot until it lands or has read all SLOTS slots; a
//  list scans every slot once; a vacate scans twice, once to settle the
//  occupied count and once to mark and report; an unknown type goes straight
//  to its summary. A stalled output register holds the scan; nothing is lost.
//  Reset clears all slots to empty through a written-flag per slot, at once;
//  the RAM itself needs no clearing pass. Scan reads and writes never hit
//  the same slot in one cycle, so the RAM needs no forwarding path.
// ----------------------------------------------------------------------------
module hash_slot_allocator_linear_probe_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [hsa_pkg::TYPE_W-1:0]   req_type,
	input  wire logic [hsa_pkg::SEED_W-1:0]   hash_seed,
	input  wire logic [hsa_pkg::KEY_W-1:0]    key_code,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic      [hsa_pkg::SIDX_W-1:0]   slot_index,
	output logic      [hsa_pkg::KEY_W-1:0]    slot_key,
	output logic      [hsa_pkg::CODE_W-1:0]   result_code,
	output logic      [hsa_pkg::CNT_W-1:0]    free_count,
	output logic      [hsa_pkg::CNT_W-1:0]    used_count,
	output logic                              last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FULL = 4'b0100,
		ST_SUMM = 4'b1000
	} state_t;

	state_t                         state_q;
	logic   [hsa_pkg::TYPE_W-1:0]   type_q;
	logic   [hsa_pkg::KEY_W-1:0]    key_q;
	logic                           vac2_q;     // second vacate pass
	logic   [hsa_pkg::IDX_W-1:0]    floc_q;     // next slot to fetch
	logic   [hsa_pkg::FC_W-1:0]     fcnt_q;     // fetches issued
	logic                           valid_s1;   // RAM data valid for loc_s1
	logic   [hsa_pkg::IDX_W-1:0]    loc_s1;
	logic   [hsa_pkg::CNT_W-1:0]    used_q;
	logic   [hsa_pkg::SLOTS-1:0]    written_q;

	logic                           req_acc;
	logic                           is_scan, is_full, is_summ;
	hsa_pkg::slot_word_t            rd_word;
	logic   [hsa_pkg::WORD_W-1:0]   ram_rdata;
	hsa_pkg::slot_word_t            wr_word;
	logic                           slot_written, occ_hit, key_hit;
	logic                           want_emit, vac_dec;
	logic   [hsa_pkg::CODE_W-1:0]   scan_code;
	logic   [hsa_pkg::KEY_W-1:0]    scan_key;
	logic                           scan_emit, scan_fire, hold;
	logic                           park_done, issue, scan_end;
	logic                           ram_wr_en;
	logic                           out_ready, push;
	hsa_pkg::rsp_t                  push_data, rsp_data;
	logic   [hsa_pkg::CNT_W-1:0]    emit_used;

	assign is_scan   = (state_q == ST_SCAN);
	assign is_full   = (state_q == ST_FULL);
	assign is_summ   = (state_q == ST_SUMM);
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// ---------------- slot evaluation on RAM read data ----------------
	always_comb begin
		rd_word      = hsa_pkg::slot_word_t'(ram_rdata);
		slot_written = written_q[loc_s1];
		occ_hit      = slot_written && rd_word.occ;
		key_hit      = slot_written && (rd_word.key == key_q);
		want_emit    = 1'b0;
		vac_dec      = 1'b0;
		scan_code    = hsa_pkg::RC_SUMMARY;
		scan_key     = rd_word.key;
		case (type_q)
			hsa_pkg::REQ_PARK: begin
				// first empty or left slot takes the key
				want_emit = !occ_hit;
				scan_code = hsa_pkg::RC_PARKED;
				scan_key  = key_q;
			end
			hsa_pkg::REQ_VACATE: begin
				// pass one only counts occupied matches, pass two marks and reports every match, left slots too
				want_emit = vac2_q && key_hit;
				vac_dec   = !vac2_q && key_hit && rd_word.occ;
				scan_code = hsa_pkg::RC_VACATED;
			end
			hsa_pkg::REQ_LIST: begin
				want_emit = occ_hit;
				scan_code = hsa_pkg::RC_LISTED;
			end
			default: begin
			end
		endcase
	end

	assign scan_emit = is_scan && valid_s1 && want_emit;
	assign hold      = scan_emit && !out_ready;
	assign scan_fire = scan_emit && out_ready;
	assign park_done = scan_fire && (type_q == hsa_pkg::REQ_PARK);
	assign issue     = is_scan && !hold && !park_done
	                   && (fcnt_q != hsa_pkg::FC_W'(hsa_pkg::SLOTS));
	assign scan_end  = is_scan && !valid_s1
	                   && (fcnt_q == hsa_pkg::FC_W'(hsa_pkg::SLOTS));

	// write back on the beat that reports the slot
	assign ram_wr_en = scan_fire && (type_q != hsa_pkg::REQ_LIST);
	always_comb begin
		wr_word.occ = (type_q == hsa_pkg::REQ_PARK);
		wr_word.key = (type_q == hsa_pkg::REQ_PARK) ? key_q : rd_word.key;
	end

	hsa_ram #(
		.WIDTH (hsa_pkg::WORD_W),
		.DEPTH (hsa_pkg::SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (loc_s1),
		.wr_data (wr_word),
		.rd_en   (issue),
		.rd_addr (floc_q),
		.rd_data (ram_rdata)
	);

	// ---------------- result beat ----------------
	assign push = (scan_emit || is_full || is_summ) && out_ready;

	always_comb begin
		emit_used = (is_scan && type_q == hsa_pkg::REQ_PARK)
		            ? used_q + hsa_pkg::CNT_W'(1) : used_q;
		push_data.free_count = hsa_pkg::CNT_W'(hsa_pkg::SLOTS) - emit_used;
		push_data.used_count = emit_used;
		push_data.slot_index = '0;
		push_data.slot_key   = '0;
		push_data.result_code = hsa_pkg::RC_SUMMARY;
		push_data.last       = 1'b0;
		if (is_scan) begin
			push_data.slot_index  = hsa_pkg::SIDX_W'(loc_s1);
			push_data.slot_key    = scan_key;
			push_data.result_code = scan_code;
		end else if (is_full) begin
			push_data.slot_key    = key_q;
			push_data.result_code = hsa_pkg::RC_FULL;
		end else begin
			push_data.last = 1'b1;
		end
	end

	hsa_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.ready     (out_ready),
		.stall     (rsp_stall),
		.valid     (rsp_valid),
		.data      (rsp_data)
	);

	assign slot_index  = rsp_data.slot_index;
	assign slot_key    = rsp_data.slot_key;
	assign result_code = rsp_data.result_code;
	assign free_count  = rsp_data.free_count;
	assign used_count  = rsp_data.used_count;
	assign last        = rsp_data.last;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vac2_q    <= 1'b0;
			fcnt_q    <= '0;
			valid_s1  <= 1'b0;
			used_q    <= '0;
			written_q <= '0;
		end else begin
			// no fetch goes out on the parking beat, so the stage empties
			if (is_scan && !hold) begin
				valid_s1 <= issue;
			end
			if (issue) begin
				fcnt_q <= fcnt_q + hsa_pkg::FC_W'(1);
			end
			if (park_done) begin
				used_q            <= used_q + hsa_pkg::CNT_W'(1);
				written_q[loc_s1] <= 1'b1;
			end
			if (is_scan && valid_s1 && vac_dec) begin
				used_q <= used_q - hsa_pkg::CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						fcnt_q   <= '0;
						valid_s1 <= 1'b0;
						vac2_q   <= 1'b0;
						if (req_type == hsa_pkg::REQ_PARK
						    || req_type == hsa_pkg::REQ_VACATE
						    || req_type == hsa_pkg::REQ_LIST) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_SUMM;
						end
					end
				end
				ST_SCAN: begin
					if (park_done) begin
						state_q <= ST_SUMM;
					end else if (scan_end) begin
						if (type_q == hsa_pkg::REQ_PARK) begin
							state_q <= ST_FULL;
						end else if (type_q == hsa_pkg::REQ_VACATE && !vac2_q) begin
							vac2_q <= 1'b1;
							fcnt_q <= '0;
						end else begin
							state_q <= ST_SUMM;
						end
					end
				end
				ST_FULL: begin
					if (out_ready) begin
						state_q <= ST_SUMM;
					end
				end
				ST_SUMM: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fetch pointer and request payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			type_q <= req_type;
			key_q  <= key_code;
			floc_q <= (req_type == hsa_pkg::REQ_PARK) ? hsa_pkg::HOME_TBL[hash_seed] : '0;
		end else if (issue) begin
			floc_q <= (floc_q == hsa_pkg::IDX_W'(hsa_pkg::SLOTS - 1))
			          ? '0 : floc_q + hsa_pkg::IDX_W'(1);
		end else if (scan_end && type_q == hsa_pkg::REQ_VACATE && !vac2_q) begin
			floc_q <= '0;
		end
		if (is_scan && !hold) begin
			loc_s1 <= floc_q;
		end
	end

	// ---------------- assertions ----------------
	a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && ram_wr_en) |-> (floc_q != loc_s1))
		else $error("RAM read and write hit the same slot");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= hsa_pkg::CNT_W'(hsa_pkg::SLOTS))
		else $error("occupied count above table size");

	a_hold_keeps_slot: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> (valid_s1 && $stable(loc_s1)))
		else $error("evaluated slot moved during output stall");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request accepted but block did not go busy");

	a_summary_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(is_summ && out_ready) |=> !req_stall)
		else $error("summary sent but block still busy");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear-probe slot allocator. A scoreboard
// class keeps its own copy of the slot table, predicts every result beat of
// each accepted request and checks the beats in order. Directed requests hit
// the corner cases; random requests on a small key pool follow. Both
// channels idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;
	import hsa_pkg::*;

	// no package name for the fourth request encoding; the block must ignore it
	localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

	localparam int RANDOM_ITEMS     = 86;
	localparam int CALM_ITEMS       = 20;   // tail of the run with no idling at all
	localparam int POOL_SIZE        = 6;
	localparam int LONG_HOLD_AFTER  = 80;   // beats taken before the long receiver hold
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int QUIET_CYCLES     = 40;   // longer than a whole vacate request
	localparam int MAX_PRINTED      = 40;
	localparam longint TIMEOUT_NS   = 2_000_000;

	// slot status as the predictor tracks it
	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_OCCUPIED,
		ST_LEFT
	} slot_status_e;

	// ------------------------------------------------------------------------
	// scoreboard: shadow slot table plus the queue of beats still owed
	// ------------------------------------------------------------------------
	class slot_table_scoreboard;
		slot_status_e     status [SLOTS];
		logic [KEY_W-1:0] keys [SLOTS];
		rsp_t             owed_beats [$];
		int               errors;
		int               beats_checked;
		int               req_seen [4];
		int               code_seen [8];

		function new();
			foreach (status[s])
				status[s] = ST_EMPTY;
			errors = 0;
			beats_checked = 0;
			foreach (req_seen[k])
				req_seen[k] = 0;
			foreach (code_seen[k])
				code_seen[k] = 0;
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction

		function rsp_t make_beat(int idx, logic [KEY_W-1:0] key, logic [CODE_W-1:0] code,
				logic is_last);
			rsp_t b;
			b.slot_index  = SIDX_W'(idx);
			b.slot_key    = key;
			b.result_code = code;
			b.free_count  = '0;
			b.used_count  = '0;
			b.last        = is_last;
			return b;
		endfunction

		// apply one accepted request to the shadow table and queue its beats
		function void note_request(logic [TYPE_W-1:0] kind, logic [SEED_W-1:0] seed,
				logic [KEY_W-1:0] key);
			rsp_t beats [$];
			int   home;
			int   loc;
			int   used;
			bit   placed;
			req_seen[kind]++;
			case (kind)
				REQ_PARK: begin
					home = int'(seed) % SLOTS;
					placed = 1'b0;
					for (int i = 0; i < SLOTS && !placed; i++) begin
						loc = (home + i) % SLOTS;
						if (status[loc] != ST_OCCUPIED) begin
							status[loc] = ST_OCCUPIED;
							keys[loc] = key;
							beats.push_back(make_beat(loc, key, RC_PARKED, 1'b0));
							placed = 1'b1;
						end
					end
					if (!placed)
						beats.push_back(make_beat(0, key, RC_FULL, 1'b0));
				end
				REQ_VACATE: begin
					// tombstones still match and are reported again
					for (int i = 0; i < SLOTS; i++) begin
						if (status[i] != ST_EMPTY && keys[i] == key) begin
							status[i] = ST_LEFT;
							beats.push_back(make_beat(i, keys[i], RC_VACATED, 1'b0));
						end
					end
				end
				REQ_LIST: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (status[i] == ST_OCCUPIED)
							beats.push_back(make_beat(i, keys[i], RC_LISTED, 1'b0));
					end
				end
				default: ;
			endcase
			beats.push_back(make_beat(0, '0, RC_SUMMARY, 1'b1));
			used = 0;
			foreach (status[s])
				if (status[s] == ST_OCCUPIED)
					used++;
			// counts after the whole request go on every beat
			foreach (beats[j]) begin
				beats[j].free_count = CNT_W'(SLOTS - used);
				beats[j].used_count = CNT_W'(used);
				owed_beats.push_back(beats[j]);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("testbench: mismatch at %0t: %s", $realtime, what);
		endtask

		task check_field(string name, logic [63:0] got_v, logic [63:0] want_v);
			if (got_v !== want_v)
				report_mismatch($sformatf("beat %0d %s got 0x%0h, expected 0x%0h",
					beats_checked, name, got_v, want_v));
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (owed_beats.size() == 0) begin
				report_mismatch($sformatf("beat with nothing owed, code %0d slot %0d",
					got.result_code, got.slot_index));
				return;
			end
			want = owed_beats.pop_front();
			beats_checked++;
			code_seen[want.result_code]++;
			check_field("slot_index", 64'(got.slot_index), 64'(want.slot_index));
			check_field("slot_key", 64'(got.slot_key), 64'(want.slot_key));
			check_field("result_code", 64'(got.result_code), 64'(want.result_code));
			check_field("free_count", 64'(got.free_count), 64'(want.free_count));
			check_field("used_count", 64'(got.used_count), 64'(want.used_count));
			check_field("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [TYPE_W-1:0] req_type = REQ_PARK;
	logic [SEED_W-1:0] hash_seed = '0;
	logic [KEY_W-1:0]  key_code = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [SIDX_W-1:0] slot_index;
	logic [KEY_W-1:0]  slot_key;
	logic [CODE_W-1:0] result_code;
	logic [CNT_W-1:0]  free_count;
	logic [CNT_W-1:0]  used_count;
	logic              last;

	// set for the tail of the run: no idling on either side
	bit calm = 1'b0;

	slot_table_scoreboard sb = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hash_slot_allocator_linear_probe_unit dut (.*);

	function automatic logic [KEY_W-1:0] random_key();
		return KEY_W'({$urandom(), $urandom()});
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// offer one request beat, hold it until taken, then log it for prediction;
	// sometimes an idle burst goes in front of it
	task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [SEED_W-1:0] seed,
			input logic [KEY_W-1:0] key);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		hash_seed <= seed;
		key_code  <= key;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(kind, seed, key);
	endtask

	// stop offering and wait until every owed beat is back
	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() > 0);
	endtask

	initial begin : stimulus
		logic [KEY_W-1:0]  key_pool [POOL_SIZE];
		logic [KEY_W-1:0]  hot_key;
		logic [KEY_W-1:0]  key;
		logic [TYPE_W-1:0] kind;
		int                pick;

		foreach (key_pool[p])
			key_pool[p] = random_key();
		hot_key = random_key();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unknown type, seed extremes, wrap-around
		send_request(REQ_LIST, 7'd0, '0);
		send_request(REQ_VACATE, 7'd0, '0);          // no written slots, no match
		send_request(REQ_UNKNOWN, 7'd55, hot_key);
		send_request(REQ_PARK, 7'd0, '1);            // slot 0, all-ones key
		send_request(REQ_PARK, 7'd127, '0);          // seed past 99 -> slot 7
		send_request(REQ_PARK, 7'd99, hot_key);      // slot 9
		send_request(REQ_PARK, 7'd9, hot_key);       // 9 taken, wraps past 0 to 1
		send_request(REQ_VACATE, 7'd3, hot_key);     // two matches
		send_request(REQ_VACATE, 7'd3, hot_key);     // tombstones reported again
		send_request(REQ_LIST, 7'd64, '1);
		// fill the rest, reusing tombstones at 1 and 9
		for (int i = 0; i < SLOTS - 2; i++)
			send_request(REQ_PARK, 7'($urandom_range(0, 127)), key_pool[i % POOL_SIZE]);
		send_request(REQ_PARK, 7'd42, random_key()); // table full
		send_request(REQ_LIST, 7'd1, '0);            // every slot listed
		send_request(REQ_VACATE, 7'd2, '1);          // frees slot 0
		send_request(REQ_PARK, 7'd3, random_key());  // probes 3..9, lands on 0
		send_request(REQ_UNKNOWN, 7'd127, '1);
		send_request(REQ_VACATE, 7'd0, '0);          // key zero stored at slot 7

		// sender pause: let the whole directed part come back first
		drain_results();

		// random: mostly pool keys so vacates find matches and slots churn
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				kind = REQ_PARK;
			else if (pick < 78)
				kind = REQ_VACATE;
			else if (pick < 95)
				kind = REQ_LIST;
			else
				kind = REQ_UNKNOWN;
			key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
				: random_key();
			send_request(kind, 7'($urandom_range(0, 127)), key);
		end

		drain_results();
		// any stray beat after the last summary shows up here as a mismatch
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("testbench: %0d requests: park %0d, vacate %0d, list %0d, unknown %0d",
			sb.req_seen[REQ_PARK] + sb.req_seen[REQ_VACATE] + sb.req_seen[REQ_LIST]
			+ sb.req_seen[REQ_UNKNOWN], sb.req_seen[REQ_PARK], sb.req_seen[REQ_VACATE],
			sb.req_seen[REQ_LIST], sb.req_seen[REQ_UNKNOWN]);
		$display("testbench: %0d beats: parked %0d, full %0d, vacated %0d, listed %0d; %0d bad",
			sb.beats_checked, sb.code_seen[RC_PARKED], sb.code_seen[RC_FULL],
			sb.code_seen[RC_VACATED], sb.code_seen[RC_LISTED], sb.errors);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// result side: take beats, check them, stall in random bursts
	// ------------------------------------------------------------------------
	initial begin : result_side
		rsp_t got;
		int   stall_left;
		int   beats_taken;
		bit   long_hold_done;
		stall_left = 0;
		beats_taken = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				got.slot_index  = slot_index;
				got.slot_key    = slot_key;
				got.result_code = result_code;
				got.free_count  = free_count;
				got.used_count  = used_count;
				got.last        = last;
				sb.check_result(got);
				beats_taken++;
			end
			// one long hold: the block backs up and must stall its request side
			if (!long_hold_done && beats_taken >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== hash_slot_allocator_linear_probe_unit.f =====
src/hsa_pkg.sv
src/hsa_ram.sv
src/hsa_out.sv
src/hash_slot_allocator_linear_probe_unit.sv
dv/testbench.sv
